// ----- rtl/acp_pkg.sv -----
// Shared types and constants of the arena compaction planner.
`default_nettype none
package acp_pkg;

  localparam int MAX_FREE_RANGES = 16;
  localparam int SPAN_DEPTH      = MAX_FREE_RANGES + 1;
  localparam int FREE_IDX_W      = $clog2(MAX_FREE_RANGES);
  localparam int CNT_W           = $clog2(MAX_FREE_RANGES + 2);
  localparam int DATA_W          = 32;
  localparam int CAP_W           = 34;
  localparam int CFG_IDX_W       = 2;
  localparam int KIND_W          = 3;
  localparam int GROW_W          = 66;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_GROWTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_CAPACITY = 2'd2;

  // Input commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SPAN     = 3'd0,
    KIND_RELOC    = 3'd1,
    KIND_INVALID  = 3'd2,
    KIND_NOTCOV   = 3'd3,
    KIND_EMPTY    = 3'd4,
    KIND_OVERFLOW = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAP,
    ST_SCAN,
    ST_PICK,
    ST_FLUSH,
    ST_TAIL,
    ST_DECIDE,
    ST_EMIT,
    ST_QUERY,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/arena_compaction_planner.sv -----
// Top level of the arena compaction planner: loader, plan sequencer and query walker.
`default_nettype none
// Load words are taken while the block is idle. A load word marked last builds
// the plan: the expanded capacity is found by doubling, one shift per cycle,
// then the kept free ranges are pulled out in order of start by repeated scans
// of the free range store, one entry per cycle, and the copy spans are then
// delivered as result words. A relocate query walks the span store one entry
// per cycle. The block takes no input word while a plan or a query is in
// progress; configuration writes are always taken.
module arena_compaction_planner (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acp_pkg::DATA_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [acp_pkg::DATA_W-1:0]    in_range_start,
  input  logic [acp_pkg::DATA_W-1:0]    in_range_count,
  input  logic                          in_last_range,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [acp_pkg::KIND_W-1:0]    out_result_kind,
  output logic [acp_pkg::DATA_W-1:0]    out_source_start,
  output logic [acp_pkg::DATA_W-1:0]    out_dest_start,
  output logic [acp_pkg::DATA_W-1:0]    out_span_count,
  output logic [acp_pkg::CAP_W-1:0]     out_new_capacity,
  output logic [acp_pkg::DATA_W-1:0]    out_relocated_total,
  output logic                          out_last_result
);
  import acp_pkg::*;

  // Configuration registers.
  logic [DATA_W-1:0] cur_cap_r, req_grow_r, def_cap_r;

  // Free range store and plan state.
  logic [DATA_W-1:0] free_start_r [MAX_FREE_RANGES];
  logic [DATA_W-1:0] free_count_r [MAX_FREE_RANGES];
  logic [MAX_FREE_RANGES-1:0] done_r;
  logic [CNT_W-1:0] fill_r;
  logic             ovf_r;

  // Span store.
  logic [DATA_W-1:0] span_start_r [SPAN_DEPTH];
  logic [DATA_W-1:0] span_count_r [SPAN_DEPTH];
  logic [DATA_W-1:0] span_dest_r  [SPAN_DEPTH];
  logic [CNT_W-1:0]  span_total_r;

  // Sequencer working registers.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  idx_r;
  logic [GROW_W-1:0] grow_r;
  logic              best_found_r;
  logic [DATA_W-1:0] best_s_r;
  logic [DATA_W:0]   best_e_r;
  logic [FREE_IDX_W-1:0] best_idx_r;
  logic              have_r;
  logic [DATA_W:0]   ms_r, me_r, src_r;
  logic [DATA_W-1:0] dst_r, tot_r;
  logic [DATA_W-1:0] q_s_r, q_c_r, res_dst_r;
  kind_t             res_kind_r;

  // Output register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [DATA_W-1:0] out_src_r, out_dst_r, out_cnt_r, out_tot_r;
  logic [CAP_W-1:0]  out_cap_r;
  logic              out_last_r;

  logic in_acc, out_free;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Capacity growth test for one doubling step.
  logic [DATA_W-1:0] floor_cap;
  logic              grow_more;
  always_comb begin
    floor_cap = (def_cap_r > req_grow_r) ? def_cap_r : req_grow_r;
    if (cur_cap_r == '0) begin
      grow_more = grow_r < {{(GROW_W-DATA_W){1'b0}}, floor_cap};
    end else begin
      grow_more = (grow_r - {{(GROW_W-DATA_W){1'b0}}, cur_cap_r})
                  < {{(GROW_W-DATA_W){1'b0}}, req_grow_r};
    end
  end

  // Store entry under the scan pointer, cut to the capacity.
  logic [DATA_W-1:0] scan_s, scan_c;
  logic [DATA_W:0]   scan_e;
  logic              scan_kept, scan_more;
  always_comb begin
    scan_s    = free_start_r[idx_r[FREE_IDX_W-1:0]];
    scan_c    = free_count_r[idx_r[FREE_IDX_W-1:0]];
    scan_e    = {1'b0, scan_s} + {1'b0, scan_c};
    if (scan_e > {1'b0, cur_cap_r}) begin
      scan_e = {1'b0, cur_cap_r};
    end
    scan_more = idx_r < fill_r;
    scan_kept = (scan_c != '0) && (scan_s < cur_cap_r)
                && !done_r[idx_r[FREE_IDX_W-1:0]]
                && (!best_found_r || scan_s < best_s_r);
  end

  logic merge_join;
  assign merge_join = have_r && (me_r >= {1'b0, best_s_r});

  // Span generator: at most one stop point per cycle.
  logic            gen_fire, gen_has_en, gen_add;
  logic [DATA_W:0] gen_stop, gen_en, gen_used;
  always_comb begin
    gen_fire   = 1'b0;
    gen_has_en = 1'b0;
    gen_stop   = ms_r;
    gen_en     = me_r;
    unique case (state_r)
      ST_PICK:  gen_fire = have_r && !merge_join;
      ST_FLUSH: gen_fire = have_r;
      ST_TAIL: begin
        gen_fire = 1'b1;
        gen_stop = {1'b0, cur_cap_r};
      end
      default: gen_fire = 1'b0;
    endcase
    gen_has_en = gen_fire && (state_r != ST_TAIL);
    gen_used   = gen_stop - src_r;
    gen_add    = gen_fire && (gen_stop > src_r);
  end

  // Span under the walk pointer against the queried allocation.
  logic [DATA_W-1:0] q_ss, q_sc;
  logic              q_hit, q_more;
  always_comb begin
    q_ss   = span_start_r[idx_r];
    q_sc   = span_count_r[idx_r];
    q_more = idx_r < span_total_r;
    q_hit  = (q_sc != '0) && (q_s_r >= q_ss)
             && (({1'b0, q_s_r} + {1'b0, q_c_r}) <= ({1'b0, q_ss} + {1'b0, q_sc}));
  end

  logic emit_last;
  assign emit_last = (idx_r == span_total_r - CNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == CMD_QUERY) begin
            state_nxt = (in_range_count == '0) ? ST_RESP : ST_QUERY;
          end else if (in_last_range) begin
            state_nxt = ST_CAP;
          end
        end
      end
      ST_CAP: begin
        if (!grow_more) begin
          state_nxt = (ovf_r || cur_cap_r == '0) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more) begin
          state_nxt = best_found_r ? ST_PICK : ST_FLUSH;
        end
      end
      ST_PICK:   state_nxt = ST_SCAN;
      ST_FLUSH:  state_nxt = ST_TAIL;
      ST_TAIL:   state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = (span_total_r == '0) ? ST_RESP : ST_EMIT;
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (!q_more || q_hit) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_cap_r    <= '0;
      req_grow_r   <= '0;
      def_cap_r    <= '0;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      span_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CURRENT_CAPACITY: cur_cap_r  <= cfg_data;
          REG_REQUESTED_GROWTH: req_grow_r <= cfg_data;
          REG_DEFAULT_CAPACITY: def_cap_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && in_command == CMD_LOAD) begin
        if (fill_r < CNT_W'(MAX_FREE_RANGES)) begin
          fill_r <= fill_r + CNT_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
        if (in_last_range) begin
          span_total_r <= '0;
        end
      end
      if (state_r == ST_CAP && !grow_more && (ovf_r || cur_cap_r == '0)) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (state_r == ST_FLUSH) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end
      if (gen_add) begin
        span_total_r <= span_total_r + CNT_W'(1);
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_EMIT || state_r == ST_RESP) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Store a load word.
    if (in_acc && in_command == CMD_LOAD && fill_r < CNT_W'(MAX_FREE_RANGES)) begin
      free_start_r[fill_r[FREE_IDX_W-1:0]] <= in_range_start;
      free_count_r[fill_r[FREE_IDX_W-1:0]] <= in_range_count;
    end
    // Store a new copy span.
    if (gen_add) begin
      span_start_r[span_total_r] <= src_r[DATA_W-1:0];
      span_count_r[span_total_r] <= gen_used[DATA_W-1:0];
      span_dest_r[span_total_r]  <= dst_r;
      dst_r <= dst_r + gen_used[DATA_W-1:0];
      tot_r <= tot_r + gen_used[DATA_W-1:0];
    end
    if (gen_has_en && gen_en > src_r) begin
      src_r <= gen_en;
    end

    unique case (state_r)
      ST_IDLE: begin
        q_s_r        <= in_range_start;
        q_c_r        <= in_range_count;
        res_kind_r   <= KIND_INVALID;
        idx_r        <= '0;
        best_found_r <= 1'b0;
        have_r       <= 1'b0;
        done_r       <= '0;
        src_r        <= '0;
        dst_r        <= '0;
        tot_r        <= '0;
        grow_r       <= (cur_cap_r == '0) ? GROW_W'(1)
                                          : {{(GROW_W-DATA_W){1'b0}}, cur_cap_r};
      end
      ST_CAP: begin
        if (grow_more) begin
          grow_r <= {grow_r[GROW_W-2:0], 1'b0};
        end else begin
          res_kind_r <= ovf_r ? KIND_OVERFLOW : KIND_EMPTY;
        end
      end
      ST_SCAN: begin
        if (scan_more) begin
          idx_r <= idx_r + CNT_W'(1);
          if (scan_kept) begin
            best_found_r <= 1'b1;
            best_s_r     <= scan_s;
            best_e_r     <= scan_e;
            best_idx_r   <= idx_r[FREE_IDX_W-1:0];
          end
        end
      end
      ST_PICK: begin
        done_r[best_idx_r] <= 1'b1;
        idx_r        <= '0;
        best_found_r <= 1'b0;
        if (merge_join) begin
          if (best_e_r > me_r) begin
            me_r <= best_e_r;
          end
        end else begin
          ms_r   <= {1'b0, best_s_r};
          me_r   <= best_e_r;
          have_r <= 1'b1;
        end
      end
      ST_DECIDE: begin
        idx_r      <= '0;
        res_kind_r <= KIND_EMPTY;
      end
      ST_EMIT: begin
        if (out_free) begin
          idx_r      <= idx_r + CNT_W'(1);
          out_kind_r <= KIND_SPAN;
          out_src_r  <= span_start_r[idx_r];
          out_dst_r  <= span_dest_r[idx_r];
          out_cnt_r  <= span_count_r[idx_r];
          out_cap_r  <= emit_last ? grow_r[CAP_W-1:0] : '0;
          out_tot_r  <= emit_last ? tot_r : '0;
          out_last_r <= emit_last;
        end
      end
      ST_QUERY: begin
        if (q_more && q_hit) begin
          res_kind_r <= KIND_RELOC;
          res_dst_r  <= span_dest_r[idx_r] + (q_s_r - q_ss);
        end else if (q_more) begin
          idx_r <= idx_r + CNT_W'(1);
        end else begin
          res_kind_r <= KIND_NOTCOV;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_kind_r <= res_kind_r;
          out_last_r <= 1'b1;
          out_tot_r  <= '0;
          out_src_r  <= '0;
          out_dst_r  <= '0;
          out_cnt_r  <= '0;
          out_cap_r  <= '0;
          unique case (res_kind_r)
            KIND_EMPTY: out_cap_r <= grow_r[CAP_W-1:0];
            KIND_INVALID: out_src_r <= q_s_r;
            KIND_NOTCOV: begin
              out_src_r <= q_s_r;
              out_cnt_r <= q_c_r;
            end
            KIND_RELOC: begin
              out_src_r <= q_s_r;
              out_dst_r <= res_dst_r;
              out_cnt_r <= q_c_r;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // Result port.
  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_source_start    = out_src_r;
  assign out_dest_start      = out_dst_r;
  assign out_span_count      = out_cnt_r;
  assign out_new_capacity    = out_cap_r;
  assign out_relocated_total = out_tot_r;
  assign out_last_result     = out_last_r;

`ifndef SYNTH
  // The free range store never holds more than its depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(MAX_FREE_RANGES)) else $error("free range fill past depth");

  // A plan never makes more spans than the span store depth.
  a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
    span_total_r <= CNT_W'(SPAN_DEPTH)) else $error("span count past depth");

  // The scan pointer never runs beyond the fill.
  a_scan_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= fill_r) else $error("scan pointer past fill");

  // Span delivery reads only stored spans.
  a_emit_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> idx_r < span_total_r) else $error("emit pointer past spans");
`endif

endmodule
`default_nettype wire
